### sv/psl_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// psl_pkg
// Shared widths, request and status codes, cell operations and the control
// struct that the list controller hands to every storage cell.
// -----------------------------------------------------------------------------
package psl_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int CAPACITY_MAX = 64;
   localparam int SYM_W        = 8;
   localparam int CNT_W        = 7;
   localparam int POS_W        = 8;
   localparam int IDX_W        = $clog2(CAPACITY_MAX);

   localparam logic [1:0] REQ_ADD    = 2'd0;
   localparam logic [1:0] REQ_DELETE = 2'd1;
   localparam logic [1:0] REQ_GET    = 2'd2;
   localparam logic [1:0] REQ_PRINT  = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_INVALID = 2'd1;
   localparam logic [1:0] ST_FULL    = 2'd2;
   localparam logic [1:0] ST_EMPTY   = 2'd3;

   localparam logic [1:0] CELL_HOLD   = 2'd0;
   localparam logic [1:0] CELL_INSERT = 2'd1;
   localparam logic [1:0] CELL_DELETE = 2'd2;
   localparam logic [1:0] CELL_ROTATE = 2'd3;

   typedef struct packed {
      logic [1:0]       op;
      logic [IDX_W-1:0] idx;
      logic [CNT_W-1:0] cnt;
      logic [SYM_W-1:0] sym;
   } psl_ctl_type;

endpackage
`default_nettype wire

### sv/psl_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// psl_cell
// One list slot. Loads the new symbol, takes a neighbor's symbol on insert,
// delete or rotate, or holds.
// -----------------------------------------------------------------------------
module psl_cell #(
   parameter int INDEX = 0
) (
   input  wire                        clock,
   input  psl_pkg::psl_ctl_type       ctl,
   input  wire  [psl_pkg::SYM_W-1:0]  left_value,
   input  wire  [psl_pkg::SYM_W-1:0]  right_value,
   input  wire  [psl_pkg::SYM_W-1:0]  head_value,
   output logic [psl_pkg::SYM_W-1:0]  value_out
);

   localparam logic [psl_pkg::CNT_W-1:0] SLOT = psl_pkg::CNT_W'(INDEX);

   logic [psl_pkg::SYM_W-1:0] value_ff;
   logic [psl_pkg::SYM_W-1:0] value_in;
   logic [psl_pkg::CNT_W-1:0] idx_ext;
   logic [psl_pkg::CNT_W-1:0] tail;

   assign idx_ext = psl_pkg::CNT_W'(ctl.idx);
   assign tail    = ctl.cnt - psl_pkg::CNT_W'(1);

   always_comb begin
      value_in = value_ff;
      case (ctl.op)
         psl_pkg::CELL_INSERT: begin
            if (SLOT == idx_ext) begin
               value_in = ctl.sym;
            end else if (SLOT > idx_ext) begin
               value_in = left_value;
            end
         end
         psl_pkg::CELL_DELETE: begin
            if (SLOT >= idx_ext) begin
               value_in = right_value;
            end
         end
         psl_pkg::CELL_ROTATE: begin
            if (SLOT == tail) begin
               value_in = head_value;
            end else if (SLOT < tail) begin
               value_in = right_value;
            end
         end
         default: value_in = value_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      value_ff <= value_in;
   end

   assign value_out = value_ff;

endmodule
`default_nettype wire

### sv/positional_symbol_list.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// positional_symbol_list
// Ordered list of byte symbols addressed by 1-based rank, kept in a row of
// shift cells. Add, delete, get and print requests.
//
//   channel  direction  handshake            payload
//   req      in         req_valid/req_stall  req_type, req_position,
//                                            req_symbol_in
//   rsp      out        rsp_valid/rsp_stall  rsp_status, rsp_symbol_out,
//                                            rsp_count_out, rsp_last
//
// Add, delete and get results are registered.
// Print on an empty list gives one empty result; otherwise it starts a run in
// which the cell row rotates by one rank per emitted symbol and is back in
// order after the last one.
// req_stall is high during a print run and while a result waits.
// Synchronous active-high reset empties the list; cell contents are not reset.
// -----------------------------------------------------------------------------
module positional_symbol_list #(
   parameter int CAPACITY = psl_pkg::CAPACITY_DEF
) (
   input  wire                        clock,
   input  wire                        reset,
   input  wire                        req_valid,
   output logic                       req_stall,
   input  wire  [1:0]                 req_type,
   input  wire  [psl_pkg::POS_W-1:0]  req_position,
   input  wire  [psl_pkg::SYM_W-1:0]  req_symbol_in,
   output logic                       rsp_valid,
   input  wire                        rsp_stall,
   output logic [1:0]                 rsp_status,
   output logic [psl_pkg::SYM_W-1:0]  rsp_symbol_out,
   output logic [psl_pkg::CNT_W-1:0]  rsp_count_out,
   output logic                       rsp_last
);

   localparam int SEL_W = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
   localparam logic [psl_pkg::CNT_W-1:0] CAP = psl_pkg::CNT_W'(CAPACITY);

   localparam logic STATE_IDLE = 1'b0;
   localparam logic STATE_LIST = 1'b1;

   logic                       state_ff, state_in;
   logic [psl_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [psl_pkg::CNT_W-1:0]  rem_ff, rem_in;
   logic                       rsp_valid_ff, rsp_valid_in;
   logic [1:0]                 status_ff, status_in;
   logic [psl_pkg::SYM_W-1:0]  symbol_ff, symbol_in;
   logic [psl_pkg::CNT_W-1:0]  cnt_out_ff, cnt_out_in;
   logic                       last_ff, last_in;

   logic                       out_free;
   logic                       accept;
   logic [psl_pkg::POS_W-1:0]  pos_m1;
   logic [psl_pkg::IDX_W-1:0]  idx;
   logic                       add_ok_rank;
   logic                       rank_ok;
   logic                       full;
   logic [psl_pkg::SYM_W-1:0]  get_value;
   psl_pkg::psl_ctl_type       ctl;

   logic [psl_pkg::SYM_W-1:0]  cell_q [CAPACITY];

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != STATE_IDLE) || !out_free;
   assign accept    = req_valid && !req_stall;

   assign pos_m1      = req_position - psl_pkg::POS_W'(1);
   assign idx         = pos_m1[psl_pkg::IDX_W-1:0];
   assign add_ok_rank = (req_position != '0) &&
                        ({1'b0, req_position} <= ({2'b00, count_ff} + 9'd1));
   assign rank_ok     = (req_position != '0) && (req_position <= {1'b0, count_ff});
   assign full        = (count_ff >= CAP);
   assign get_value   = cell_q[idx[SEL_W-1:0]];

   always_comb begin
      state_in     = state_ff;
      count_in     = count_ff;
      rem_in       = rem_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      status_in    = status_ff;
      symbol_in    = symbol_ff;
      cnt_out_in   = cnt_out_ff;
      last_in      = last_ff;
      ctl.op       = psl_pkg::CELL_HOLD;
      ctl.idx      = idx;
      ctl.cnt      = count_ff;
      ctl.sym      = req_symbol_in;

      if (state_ff == STATE_LIST) begin
         if (out_free) begin
            rsp_valid_in = 1'b1;
            status_in    = psl_pkg::ST_OK;
            symbol_in    = cell_q[0];
            cnt_out_in   = count_ff;
            last_in      = (rem_ff == psl_pkg::CNT_W'(1));
            ctl.op       = psl_pkg::CELL_ROTATE;
            rem_in       = rem_ff - psl_pkg::CNT_W'(1);
            if (rem_ff == psl_pkg::CNT_W'(1)) begin
               state_in = STATE_IDLE;
            end
         end
      end else if (accept) begin
         status_in = psl_pkg::ST_OK;
         symbol_in = '0;
         last_in   = 1'b1;
         case (req_type)
            psl_pkg::REQ_ADD: begin
               if (!add_ok_rank) begin
                  status_in = psl_pkg::ST_INVALID;
               end else if (full) begin
                  status_in = psl_pkg::ST_FULL;
               end else begin
                  ctl.op   = psl_pkg::CELL_INSERT;
                  count_in = count_ff + psl_pkg::CNT_W'(1);
               end
            end
            psl_pkg::REQ_DELETE: begin
               if (!rank_ok) begin
                  status_in = psl_pkg::ST_INVALID;
               end else begin
                  ctl.op   = psl_pkg::CELL_DELETE;
                  count_in = count_ff - psl_pkg::CNT_W'(1);
               end
            end
            psl_pkg::REQ_GET: begin
               if (!rank_ok) begin
                  status_in = psl_pkg::ST_INVALID;
               end else begin
                  symbol_in = get_value;
               end
            end
            default: begin
               if (count_ff == '0) begin
                  status_in = psl_pkg::ST_EMPTY;
               end else begin
                  state_in = STATE_LIST;
                  rem_in   = count_ff;
               end
            end
         endcase
         cnt_out_in   = count_in;
         rsp_valid_in = !((req_type == psl_pkg::REQ_PRINT) && (count_ff != '0));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= STATE_IDLE;
         count_ff     <= '0;
         rem_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rem_ff       <= rem_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      status_ff  <= status_in;
      symbol_ff  <= symbol_in;
      cnt_out_ff <= cnt_out_in;
      last_ff    <= last_in;
   end

   genvar g;
   generate
      for (g = 0; g < CAPACITY; g++) begin : g_cell
         logic [psl_pkg::SYM_W-1:0] left_v;
         logic [psl_pkg::SYM_W-1:0] right_v;
         if (g == 0) begin : g_first
            assign left_v = cell_q[g];
         end else begin : g_mid_l
            assign left_v = cell_q[g-1];
         end
         if (g == CAPACITY - 1) begin : g_last
            assign right_v = cell_q[g];
         end else begin : g_mid_r
            assign right_v = cell_q[g+1];
         end
         psl_cell #(
            .INDEX (g)
         ) u_cell (
            .clock       (clock),
            .ctl         (ctl),
            .left_value  (left_v),
            .right_value (right_v),
            .head_value  (cell_q[0]),
            .value_out   (cell_q[g])
         );
      end
   endgenerate

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = status_ff;
   assign rsp_symbol_out = symbol_ff;
   assign rsp_count_out  = cnt_out_ff;
   assign rsp_last       = last_ff;

endmodule
`default_nettype wire

### sv/psl_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// -----------------------------------------------------------------------------
// psl_checker
// Port-level checks on the result channel of the symbol list.
// -----------------------------------------------------------------------------
module psl_checker #(
   parameter int CAPACITY = psl_pkg::CAPACITY_DEF
) (
   input wire                        clock,
   input wire                        reset,
   input wire                        rsp_valid,
   input wire                        rsp_stall,
   input wire [1:0]                  rsp_status,
   input wire [psl_pkg::SYM_W-1:0]   rsp_symbol_out,
   input wire [psl_pkg::CNT_W-1:0]   rsp_count_out,
   input wire                        rsp_last
);

   a_err_no_symbol: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != psl_pkg::ST_OK) |-> (rsp_symbol_out == '0) && rsp_last)
      else $error("error result carries a symbol or is not last");

   a_empty_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == psl_pkg::ST_EMPTY) |-> (rsp_count_out == '0))
      else $error("empty status with nonzero count");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == psl_pkg::ST_FULL)
      |-> (rsp_count_out == psl_pkg::CNT_W'(CAPACITY)))
      else $error("full status below capacity");

   a_run_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_stall && !rsp_last
      |=> rsp_valid && $stable(rsp_count_out) && (rsp_status == psl_pkg::ST_OK))
      else $error("print run broken");

   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_symbol_out) && $stable(rsp_last))
      else $error("stalled result changed");

endmodule

bind positional_symbol_list psl_checker #(
   .CAPACITY (CAPACITY)
) u_psl_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_valid),
   .rsp_stall      (rsp_stall),
   .rsp_status     (rsp_status),
   .rsp_symbol_out (rsp_symbol_out),
   .rsp_count_out  (rsp_count_out),
   .rsp_last       (rsp_last)
);
`default_nettype wire

### bench/tb_positional_symbol_list.sv
`timescale 1ns / 1ps
// -----------------------------------------------------------------------------
// tb_positional_symbol_list
// Self-checking bench for the rank-addressed symbol list. A shadow copy of the
// list predicts every result of add, delete, get and print requests. Results
// are compared in order, field by field. Directed corner cases come first,
// then random fill and drain sweeps that reach a full list, with random gaps
// on the request side and random stalls on the result side.
// -----------------------------------------------------------------------------
module tb_positional_symbol_list;

   localparam int LIST_CAP       = psl_pkg::CAPACITY_DEF;
   localparam int RANDOM_ITEMS   = 200;
   localparam int WATCHDOG_LIMIT = 2000;
   localparam int DRAIN_CYCLES   = 20;
   localparam int MAX_REPORTS    = 30;

   typedef struct {
      logic [1:0]                status;
      logic [psl_pkg::SYM_W-1:0] symbol;
      logic [psl_pkg::CNT_W-1:0] count;
      logic                      last;
   } list_result_type;

   class symbol_list_scoreboard;
      logic [psl_pkg::SYM_W-1:0] shadow_symbols[$];
      list_result_type           pending_results[$];
      int                        errors;
      int                        reports;

      function void push_result(logic [1:0] status, logic [psl_pkg::SYM_W-1:0] symbol,
                                logic last);
         list_result_type r;
         r.status = status;
         r.symbol = symbol;
         r.count  = psl_pkg::CNT_W'(shadow_symbols.size());
         r.last   = last;
         pending_results.push_back(r);
      endfunction

      function void note_request(logic [1:0] kind, logic [psl_pkg::POS_W-1:0] rank,
                                 logic [psl_pkg::SYM_W-1:0] symbol);
         int fill;
         fill = shadow_symbols.size();
         case (kind)
            psl_pkg::REQ_ADD: begin
               if (rank < 1 || rank > fill + 1)
                  push_result(psl_pkg::ST_INVALID, '0, 1'b1);
               else if (fill >= LIST_CAP)
                  push_result(psl_pkg::ST_FULL, '0, 1'b1);
               else begin
                  shadow_symbols.insert(rank - 1, symbol);
                  push_result(psl_pkg::ST_OK, '0, 1'b1);
               end
            end
            psl_pkg::REQ_DELETE: begin
               if (rank < 1 || rank > fill)
                  push_result(psl_pkg::ST_INVALID, '0, 1'b1);
               else begin
                  shadow_symbols.delete(rank - 1);
                  push_result(psl_pkg::ST_OK, '0, 1'b1);
               end
            end
            psl_pkg::REQ_GET: begin
               if (rank < 1 || rank > fill)
                  push_result(psl_pkg::ST_INVALID, '0, 1'b1);
               else
                  push_result(psl_pkg::ST_OK, shadow_symbols[rank - 1], 1'b1);
            end
            default: begin
               if (fill == 0)
                  push_result(psl_pkg::ST_EMPTY, '0, 1'b1);
               else
                  for (int i = 0; i < fill; i++)
                     push_result(psl_pkg::ST_OK, shadow_symbols[i], i == fill - 1);
            end
         endcase
      endfunction

      function void check_field(string field, logic [7:0] expected, logic [7:0] actual);
         if (actual !== expected) begin
            errors++;
            if (reports < MAX_REPORTS)
               $display("%0t: %s mismatch, expected %0h, actual %0h",
                        $time, field, expected, actual);
            reports++;
         end
      endfunction

      function void check_result(logic [1:0] status, logic [psl_pkg::SYM_W-1:0] symbol,
                                 logic [psl_pkg::CNT_W-1:0] count, logic last);
         list_result_type r;
         if (pending_results.size() == 0) begin
            errors++;
            if (reports < MAX_REPORTS)
               $display({"%0t: unexpected transfer, expected none, ",
                         "actual status %0h symbol %0h count %0h last %0b"},
                        $time, status, symbol, count, last);
            reports++;
            return;
         end
         r = pending_results.pop_front();
         check_field("status", 8'(r.status), 8'(status));
         check_field("symbol_out", r.symbol, symbol);
         check_field("count_out", 8'(r.count), 8'(count));
         check_field("last", 8'(r.last), 8'(last));
      endfunction
   endclass

   logic                      clock;
   logic                      reset;
   logic                      req_valid;
   logic                      req_stall;
   logic [1:0]                req_type;
   logic [psl_pkg::POS_W-1:0] req_position;
   logic [psl_pkg::SYM_W-1:0] req_symbol_in;
   logic                      rsp_valid;
   logic                      rsp_stall;
   logic [1:0]                rsp_status;
   logic [psl_pkg::SYM_W-1:0] rsp_symbol_out;
   logic [psl_pkg::CNT_W-1:0] rsp_count_out;
   logic                      rsp_last;

   bit quiet_phase;
   symbol_list_scoreboard ledger = new;

   positional_symbol_list #(
      .CAPACITY(LIST_CAP)
   ) u_top (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_type       (req_type),
      .req_position   (req_position),
      .req_symbol_in  (req_symbol_in),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_symbol_out (rsp_symbol_out),
      .rsp_count_out  (rsp_count_out),
      .rsp_last       (rsp_last)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic logic [psl_pkg::SYM_W-1:0] rand_sym();
      return psl_pkg::SYM_W'($urandom_range(0, 255));
   endfunction

   function automatic int pick_gap();
      int roll;
      if (quiet_phase)
         return 0;
      roll = $urandom_range(0, 99);
      if (roll < 60)
         return 0;
      if (roll < 90)
         return $urandom_range(1, 3);
      return $urandom_range(8, 30);
   endfunction

   task automatic send_request(input logic [1:0] kind,
                               input logic [psl_pkg::POS_W-1:0] rank,
                               input logic [psl_pkg::SYM_W-1:0] symbol);
      int gap;
      @(negedge clock);
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_position  <= rank;
      req_symbol_in <= symbol;
      do @(posedge clock); while (req_stall !== 1'b0);
      ledger.note_request(kind, rank, symbol);
      gap = pick_gap();
      repeat (gap) begin
         @(negedge clock);
         req_valid <= 1'b0;
      end
   endtask

   initial begin
      int hold;
      int roll;
      hold = 0;
      rsp_stall = 1'b0;
      forever begin
         @(negedge clock);
         if (quiet_phase) begin
            rsp_stall <= 1'b0;
            hold = 0;
         end else if (hold > 0) begin
            hold--;
         end else begin
            roll = $urandom_range(0, 99);
            if (roll < 50) begin
               rsp_stall <= 1'b0;
               hold = $urandom_range(0, 19);
            end else if (roll < 90) begin
               rsp_stall <= 1'b1;
               hold = $urandom_range(0, 2);
            end else begin
               rsp_stall <= 1'b1;
               hold = $urandom_range(9, 39);
            end
         end
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0)
         ledger.check_result(rsp_status, rsp_symbol_out, rsp_count_out, rsp_last);
   end

   initial begin
      int idle_cycles;
      idle_cycles = 0;
      forever begin
         @(posedge clock);
         if (reset || (req_valid === 1'b1 && req_stall === 1'b0) ||
             (rsp_valid === 1'b1 && rsp_stall === 1'b0))
            idle_cycles = 0;
         else
            idle_cycles++;
         if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("tb_positional_symbol_list failed");
            $finish;
         end
      end
   end

   initial begin
      int                        roll;
      int                        fill;
      int                        top;
      int                        full_visits;
      bit                        filling;
      logic [1:0]                kind;
      logic [psl_pkg::POS_W-1:0] rank;

      reset         = 1'b1;
      req_valid     = 1'b0;
      req_type      = psl_pkg::REQ_ADD;
      req_position  = '0;
      req_symbol_in = '0;
      quiet_phase   = 1'b0;
      filling       = 1'b1;
      full_visits   = 0;
      repeat (8) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      send_request(psl_pkg::REQ_PRINT, 8'd1, rand_sym());
      send_request(psl_pkg::REQ_GET, 8'd1, rand_sym());
      send_request(psl_pkg::REQ_DELETE, 8'd1, rand_sym());
      send_request(psl_pkg::REQ_ADD, 8'd0, 8'h33);
      send_request(psl_pkg::REQ_ADD, 8'd2, 8'h44);
      send_request(psl_pkg::REQ_ADD, 8'd1, 8'h00);
      send_request(psl_pkg::REQ_ADD, 8'd2, 8'hFF);
      send_request(psl_pkg::REQ_ADD, 8'd1, 8'hA5);
      send_request(psl_pkg::REQ_ADD, 8'd2, 8'h5A);
      send_request(psl_pkg::REQ_ADD, 8'd255, 8'h11);
      send_request(psl_pkg::REQ_GET, 8'd1, rand_sym());
      send_request(psl_pkg::REQ_GET, 8'd4, rand_sym());
      send_request(psl_pkg::REQ_GET, 8'd5, rand_sym());
      send_request(psl_pkg::REQ_GET, 8'd0, rand_sym());
      send_request(psl_pkg::REQ_GET, 8'd255, rand_sym());
      send_request(psl_pkg::REQ_PRINT, 8'd255, rand_sym());
      send_request(psl_pkg::REQ_DELETE, 8'd2, rand_sym());
      send_request(psl_pkg::REQ_DELETE, 8'd3, rand_sym());
      send_request(psl_pkg::REQ_DELETE, 8'd3, rand_sym());
      send_request(psl_pkg::REQ_DELETE, 8'd0, rand_sym());
      send_request(psl_pkg::REQ_PRINT, 8'd0, rand_sym());
      send_request(psl_pkg::REQ_DELETE, 8'd1, rand_sym());
      send_request(psl_pkg::REQ_DELETE, 8'd1, rand_sym());
      send_request(psl_pkg::REQ_PRINT, 8'd0, rand_sym());

      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         quiet_phase = (n >= 100 && n < 140);
         fill = ledger.shadow_symbols.size();
         roll = $urandom_range(0, 99);
         if (filling)
            kind = (roll < 80) ? psl_pkg::REQ_ADD : (roll < 82) ? psl_pkg::REQ_DELETE :
                   (roll < 92) ? psl_pkg::REQ_GET : psl_pkg::REQ_PRINT;
         else
            kind = (roll < 10) ? psl_pkg::REQ_ADD : (roll < 80) ? psl_pkg::REQ_DELETE :
                   (roll < 92) ? psl_pkg::REQ_GET : psl_pkg::REQ_PRINT;
         top = (kind == psl_pkg::REQ_ADD) ? fill + 1 : fill;
         roll = $urandom_range(0, 99);
         if (roll < 10 || top == 0)
            rank = psl_pkg::POS_W'($urandom_range(0, 255));
         else if (roll < 15)
            rank = psl_pkg::POS_W'(top + 1);
         else
            rank = psl_pkg::POS_W'($urandom_range(1, top));
         send_request(kind, rank, rand_sym());

         fill = ledger.shadow_symbols.size();
         if (filling && fill == LIST_CAP) begin
            full_visits++;
            if (full_visits >= 6)
               filling = 1'b0;
         end else if (!filling && fill == 0) begin
            filling = 1'b1;
            full_visits = 0;
         end
      end
      quiet_phase = 1'b0;

      @(negedge clock);
      req_valid <= 1'b0;
      while (ledger.pending_results.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (ledger.errors == 0)
         $display("tb_positional_symbol_list passed");
      else
         $display("tb_positional_symbol_list failed");
      $finish;
   end

endmodule

### filelist.f
sv/psl_pkg.sv
sv/psl_cell.sv
sv/positional_symbol_list.sv
sv/psl_checker.sv
bench/tb_positional_symbol_list.sv
